[design/fwmb_pkg.sv]
// Shared constants, types and a helper function of the midframe blend block.
package fwmb_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
  localparam int unsigned ADDR_W     = COL_W + ROW_W;
  localparam int unsigned DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned FRAC       = 5;     // flow fraction bits plus one
  localparam int unsigned COORD_W    = 19;
  localparam int unsigned WGT_W      = 2 * FRAC + 1;
  localparam int unsigned ACC_W      = 18;
  localparam int unsigned DIM_W      = 9;

  typedef enum logic [1:0] {
    FUNC_LOAD0  = 2'd0,
    FUNC_LOAD1  = 2'd1,
    FUNC_INTERP = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_BOTH  = 2'd0,
    SRC_F0    = 2'd1,
    SRC_F1    = 2'd2,
    SRC_COLOC = 2'd3
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_FIN,
    ST_PUSH
  } state_e;

  localparam logic [2:0] RD_COLOC = 3'd4;

  typedef struct packed {
    logic       take;
    logic       calc;
    logic       rd;
    logic [2:0] rd_idx;
    logic       acc;
    logic       col_cap;
    logic       push;
  } ctl_cmd_t;

  typedef struct packed {
    logic start;
    logic out_busy;
  } dp_sts_t;

  // Bilinear weight of neighbor idx (bit 0 right column, bit 1 lower row).
  function automatic logic [WGT_W-1:0] nb_weight(input logic [1:0] idx,
                                                 input logic [FRAC-1:0] dx,
                                                 input logic [FRAC-1:0] dy);
    logic [FRAC:0] wx;
    logic [FRAC:0] wy;
    wx = idx[0] ? {1'b0, dx} : ((FRAC+1)'(1) << FRAC) - {1'b0, dx};
    wy = idx[1] ? {1'b0, dy} : ((FRAC+1)'(1) << FRAC) - {1'b0, dy};
    return WGT_W'({{(WGT_W-FRAC-1){1'b0}}, wx} * {{(WGT_W-FRAC-1){1'b0}}, wy});
  endfunction

endpackage

[design/fwmb_if.sv]
// Channel interfaces: input items, result items and configuration writes.
interface fwmb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  chan_a;
  logic [7:0]  chan_b;
  logic [7:0]  chan_c;
  logic [15:0] flow_x;
  logic [15:0] flow_y;
  modport source (output valid, func, pos_x, pos_y, chan_a, chan_b, chan_c, flow_x,
                  flow_y, input ready);
  modport sink (input valid, func, pos_x, pos_y, chan_a, chan_b, chan_c, flow_x,
                flow_y, output ready);
endinterface

interface fwmb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mid_a;
  logic [7:0] mid_b;
  logic [7:0] mid_c;
  logic [1:0] source_case;
  modport source (output valid, mid_a, mid_b, mid_c, source_case, input ready);
  modport sink (input valid, mid_a, mid_b, mid_c, source_case, output ready);
endinterface

interface fwmb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/fwmb_ram.sv]
// Generic single-port RAM with registered read.
module fwmb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[design/fwmb_ctrl.sv]
// Sequencer: accept, coordinate setup, five store reads, finish and push.
module fwmb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fwmb_pkg::dp_sts_t  sts_i,
  output fwmb_pkg::ctl_cmd_t cmd_o
);
  import fwmb_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.start) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = ST_READ;
        cnt_d   = '0;
      end
      ST_READ: begin
        if (cnt_q == RD_COLOC) state_d = ST_FIN;
        else cnt_d = cnt_q + 3'd1;
      end
      ST_FIN:  state_d = ST_PUSH;
      ST_PUSH: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.rd_idx = cnt_q;
    case (state_q)
      ST_IDLE: cmd_o.take = 1'b1;
      ST_CALC: cmd_o.calc = 1'b1;
      ST_READ: begin
        cmd_o.rd  = 1'b1;
        cmd_o.acc = (cnt_q != 3'd0);
      end
      ST_FIN:  cmd_o.col_cap = 1'b1;
      ST_PUSH: cmd_o.push = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end
endmodule

[design/fwmb_dp.sv]
// Datapath: config registers, frame stores, sample coordinates, accumulators, output.
module fwmb_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  fwmb_in_if.sink            in_if,
  fwmb_out_if.source         out_if,
  fwmb_cfg_if.sink           cfg_if,
  input  fwmb_pkg::ctl_cmd_t cmd_i,
  output fwmb_pkg::dp_sts_t  sts_o
);
  import fwmb_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic             mode_q;

  // Latched item
  logic [COL_W-1:0] px_q;
  logic [ROW_W-1:0] py_q;
  logic [15:0]      vx_q, vy_q;

  // Sample setup per frame
  logic             ok0_q, ok1_q;
  logic [COL_W-1:0] x0a_q, x1a_q;
  logic [ROW_W-1:0] y0a_q, y1a_q;
  logic [FRAC-1:0]  dx0_q, dy0_q, dx1_q, dy1_q;
  logic [WGT_W-1:0] wgt0_q, wgt1_q;
  logic [ACC_W-1:0] acc0_q [3];
  logic [ACC_W-1:0] acc1_q [3];
  logic [PIX_W-1:0] col0_q, col1_q;

  logic             out_valid_q;
  logic [7:0]       oa_q, ob_q, oc_q;
  src_e             osrc_q;

  logic             accept;
  logic [DIM_W-1:0] wsat, hsat;
  logic             we0, we1;
  logic [ADDR_W-1:0] addr0, addr1;
  logic [PIX_W-1:0] rdata0, rdata1, wdata;

  assign accept = in_if.valid && cmd_i.take;
  assign in_if.ready = cmd_i.take;
  assign cfg_if.ready = 1'b1;

  assign wsat = (width_q  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : width_q;
  assign hsat = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

  assign sts_o.start = accept && (in_if.func == FUNC_INTERP)
                       && ({1'b0, in_if.pos_x} < wsat) && ({1'b0, in_if.pos_y} < hsat);
  assign sts_o.out_busy = out_valid_q && !out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      mode_q   <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_idx_e'(cfg_if.index))
        CFG_WIDTH:  width_q  <= cfg_if.data;
        CFG_HEIGHT: height_q <= cfg_if.data;
        CFG_MODE:   mode_q   <= cfg_if.data[0];
        default:    ;
      endcase
    end
  end

  // Stores: loads write in the accept cycle, reads come from the sequencer.
  assign wdata = {in_if.chan_c, in_if.chan_b, in_if.chan_a};
  assign we0 = accept && (in_if.func == FUNC_LOAD0);
  assign we1 = accept && (in_if.func == FUNC_LOAD1);

  always_comb begin
    if (cmd_i.rd && cmd_i.rd_idx == RD_COLOC) begin
      addr0 = {py_q, px_q};
      addr1 = {py_q, px_q};
    end else if (cmd_i.rd) begin
      addr0 = {y0a_q + ROW_W'(cmd_i.rd_idx[1]), x0a_q + COL_W'(cmd_i.rd_idx[0])};
      addr1 = {y1a_q + ROW_W'(cmd_i.rd_idx[1]), x1a_q + COL_W'(cmd_i.rd_idx[0])};
    end else begin
      addr0 = {in_if.pos_y, in_if.pos_x};
      addr1 = {in_if.pos_y, in_if.pos_x};
    end
  end

  fwmb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram0 (
    .clk_i, .we_i(we0), .addr_i(addr0), .wdata_i(wdata), .rdata_o(rdata0)
  );
  fwmb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram1 (
    .clk_i, .we_i(we1), .addr_i(addr1), .wdata_i(wdata), .rdata_o(rdata1)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= in_if.pos_x;
      py_q <= in_if.pos_y;
      vx_q <= in_if.flow_x;
      vy_q <= in_if.flow_y;
    end
  end

  // Coordinates with FRAC fraction bits; symmetric flow is doubled to match.
  logic signed [COORD_W-1:0] bx, by, sx, sy, c0x, c0y, c1x, c1y;
  logic [12:0] limx, limy;
  logic        dim_ok;

  always_comb begin
    bx = $signed({{(COORD_W-COL_W-FRAC){1'b0}}, px_q, {FRAC{1'b0}}});
    by = $signed({{(COORD_W-ROW_W-FRAC){1'b0}}, py_q, {FRAC{1'b0}}});
    if (mode_q) begin
      sx = $signed({{3{vx_q[15]}}, vx_q});
      sy = $signed({{3{vy_q[15]}}, vy_q});
    end else begin
      sx = $signed({{2{vx_q[15]}}, vx_q, 1'b0});
      sy = $signed({{2{vy_q[15]}}, vy_q, 1'b0});
    end
    c0x = bx - sx;
    c0y = by - sy;
    c1x = bx + sx;
    c1y = by + sy;
    dim_ok = (wsat >= DIM_W'(2)) && (hsat >= DIM_W'(2));
    limx = {8'(wsat - DIM_W'(1)), {FRAC{1'b0}}};
    limy = {8'(hsat - DIM_W'(1)), {FRAC{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok0_q <= 1'b0;
      ok1_q <= 1'b0;
    end else if (cmd_i.calc) begin
      ok0_q <= dim_ok && !c0x[COORD_W-1] && !c0y[COORD_W-1]
               && (c0x[COORD_W-2:0] < (COORD_W-1)'(limx))
               && (c0y[COORD_W-2:0] < (COORD_W-1)'(limy));
      ok1_q <= !mode_q && dim_ok && !c1x[COORD_W-1] && !c1y[COORD_W-1]
               && (c1x[COORD_W-2:0] < (COORD_W-1)'(limx))
               && (c1y[COORD_W-2:0] < (COORD_W-1)'(limy));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      x0a_q <= c0x[FRAC +: COL_W];
      y0a_q <= c0y[FRAC +: ROW_W];
      x1a_q <= c1x[FRAC +: COL_W];
      y1a_q <= c1y[FRAC +: ROW_W];
      dx0_q <= c0x[FRAC-1:0];
      dy0_q <= c0y[FRAC-1:0];
      dx1_q <= c1x[FRAC-1:0];
      dy1_q <= c1y[FRAC-1:0];
      for (int k = 0; k < 3; k++) begin
        acc0_q[k] <= '0;
        acc1_q[k] <= '0;
      end
    end else if (cmd_i.acc) begin
      for (int k = 0; k < 3; k++) begin
        acc0_q[k] <= acc0_q[k] + ACC_W'(rdata0[8*k +: 8]) * ACC_W'(wgt0_q);
        acc1_q[k] <= acc1_q[k] + ACC_W'(rdata1[8*k +: 8]) * ACC_W'(wgt1_q);
      end
    end
    if (cmd_i.rd) begin
      wgt0_q <= nb_weight(cmd_i.rd_idx[1:0], dx0_q, dy0_q);
      wgt1_q <= nb_weight(cmd_i.rd_idx[1:0], dx1_q, dy1_q);
    end
    if (cmd_i.col_cap) begin
      col0_q <= rdata0;
      col1_q <= rdata1;
    end
  end

  // Round half up, then pick or average.
  logic [7:0] s0 [3];
  logic [7:0] s1 [3];
  logic [7:0] res [3];
  logic [8:0] sum;
  src_e       src;

  always_comb begin
    if (ok0_q && ok1_q)  src = SRC_BOTH;
    else if (ok0_q)      src = SRC_F0;
    else if (ok1_q)      src = SRC_F1;
    else                 src = SRC_COLOC;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      s0[k] = 8'((acc0_q[k] + ACC_W'(1 << (2*FRAC-1))) >> (2*FRAC));
      s1[k] = 8'((acc1_q[k] + ACC_W'(1 << (2*FRAC-1))) >> (2*FRAC));
      case (src)
        SRC_BOTH:  sum = {1'b0, s0[k]} + {1'b0, s1[k]};
        SRC_F0:    sum = {s0[k], 1'b0};
        SRC_F1:    sum = {s1[k], 1'b0};
        default:   sum = {1'b0, col0_q[8*k +: 8]} + {1'b0, col1_q[8*k +: 8]};
      endcase
      res[k] = sum[8:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      oa_q   <= res[0];
      ob_q   <= res[1];
      oc_q   <= res[2];
      osrc_q <= src;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.mid_a       = oa_q;
  assign out_if.mid_b       = ob_q;
  assign out_if.mid_c       = oc_q;
  assign out_if.source_case = osrc_q;
endmodule

[design/flow_warp_midframe_blend.sv]
// Top level of the midframe blend: sequencer plus datapath.
// Load transactions write one pixel in the accept cycle; one per cycle while idle.
// Interpolate transactions step through setup, five reads of the single-port frame
// stores (four neighbors, then co-located), finish and push, then put the result out.
// The next transaction is accepted after the push, later while an earlier result
// waits. Stores are not cleared; reset (rst_ni low, async) restores width 256,
// height 256, symmetric mode, empty output.
module flow_warp_midframe_blend (
  input  logic       clk_i,
  input  logic       rst_ni,
  fwmb_in_if.sink    in_if,
  fwmb_out_if.source out_if,
  fwmb_cfg_if.sink   cfg_if
);
  import fwmb_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequence the store reads and accumulation.
  fwmb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .sts_i(sts),
    .cmd_o(cmd)
  );

  // Hold stores, config and arithmetic.
  fwmb_dp u_dp (
    .clk_i,
    .rst_ni,
    .in_if,
    .out_if,
    .cfg_if,
    .cmd_i(cmd),
    .sts_o(sts)
  );
endmodule

[tb/flow_warp_midframe_blend_tb.sv]
// Self-checking testbench of the midframe blend block: loads, interpolations, modes.
module flow_warp_midframe_blend_tb;
  import fwmb_pkg::*;

  typedef struct packed {
    logic [7:0] mid_a;
    logic [7:0] mid_b;
    logic [7:0] mid_c;
    logic [1:0] source_case;
  } mid_pix_t;

  // Track expected interpolated pixels; hold a private copy of both frames.
  class blend_scoreboard;
    logic [23:0] frame0 [DEPTH];
    logic [23:0] frame1 [DEPTH];
    int unsigned width_cfg = 256;
    int unsigned height_cfg = 256;
    bit          fwd_mode = 0;
    mid_pix_t    pending [$];
    int          errors = 0;

    function automatic bit bilinear(bit sel, longint cx, longint cy, int fb,
                                    int unsigned w, int unsigned h,
                                    output logic [23:0] pix);
      longint one, dx, dy, r0, r1, r, c;
      int x0, y0, i00;
      logic [23:0] p00, p01, p10, p11;
      pix = '0;
      if (w < 2 || h < 2) return 0;
      if (cx < 0 || cy < 0) return 0;
      if (cx >= longint'(w - 1) << fb) return 0;
      if (cy >= longint'(h - 1) << fb) return 0;
      one = longint'(1) << fb;
      x0 = int'(cx >> fb);
      y0 = int'(cy >> fb);
      dx = cx & (one - 1);
      dy = cy & (one - 1);
      i00 = y0 * MAX_WIDTH + x0;
      p00 = sel ? frame1[i00] : frame0[i00];
      p01 = sel ? frame1[i00 + 1] : frame0[i00 + 1];
      p10 = sel ? frame1[i00 + MAX_WIDTH] : frame0[i00 + MAX_WIDTH];
      p11 = sel ? frame1[i00 + MAX_WIDTH + 1] : frame0[i00 + MAX_WIDTH + 1];
      for (int k = 0; k < 3; k++) begin
        r0 = p00[8*k +: 8] * (one - dx) + p01[8*k +: 8] * dx;
        r1 = p10[8*k +: 8] * (one - dx) + p11[8*k +: 8] * dx;
        r = r0 * (one - dy) + r1 * dy;
        c = (r + (longint'(1) << (2*fb - 1))) >> (2*fb);
        if (c > 255) c = 255;
        pix[8*k +: 8] = c[7:0];
      end
      return 1;
    endfunction

    function automatic logic [23:0] halve_sum(logic [23:0] a, logic [23:0] b);
      logic [23:0] o;
      for (int k = 0; k < 3; k++) o[8*k +: 8] = 8'((9'(a[8*k +: 8]) + b[8*k +: 8]) >> 1);
      return o;
    endfunction

    function void note_item(func_e fn, logic [7:0] px, logic [7:0] py, logic [23:0] pv,
                            logic signed [15:0] fx, logic signed [15:0] fy);
      int idx, fb;
      int unsigned w, h;
      longint bx, by;
      bit ok0, ok1;
      logic [23:0] c0, c1, res;
      mid_pix_t e;
      idx = int'(py) * MAX_WIDTH + int'(px);
      if (fn == FUNC_LOAD0) begin
        frame0[idx] = pv;
      end else if (fn == FUNC_LOAD1) begin
        frame1[idx] = pv;
      end else if (fn == FUNC_INTERP) begin
        w = width_cfg > MAX_WIDTH ? MAX_WIDTH : width_cfg;
        h = height_cfg > MAX_HEIGHT ? MAX_HEIGHT : height_cfg;
        if (px >= w || py >= h) return;
        fb = fwd_mode ? 5 : 4;
        bx = longint'(px) << fb;
        by = longint'(py) << fb;
        ok1 = 0;
        c1 = '0;
        ok0 = bilinear(0, bx - fx, by - fy, fb, w, h, c0);
        if (!fwd_mode) ok1 = bilinear(1, bx + fx, by + fy, fb, w, h, c1);
        if (ok0 && ok1) begin
          res = halve_sum(c0, c1); e.source_case = SRC_BOTH;
        end else if (ok0) begin
          res = c0; e.source_case = SRC_F0;
        end else if (ok1) begin
          res = c1; e.source_case = SRC_F1;
        end else begin
          res = halve_sum(frame0[idx], frame1[idx]); e.source_case = SRC_COLOC;
        end
        e.mid_a = res[7:0];
        e.mid_b = res[15:8];
        e.mid_c = res[23:16];
        pending.push_back(e);
      end
    endfunction

    function void check_result(mid_pix_t got);
      mid_pix_t e;
      if (pending.size() == 0) begin
        report("unexpected result", got.mid_a, 8'h00);
        return;
      end
      e = pending.pop_front();
      if (got.mid_a !== e.mid_a) report("mid_a", got.mid_a, e.mid_a);
      if (got.mid_b !== e.mid_b) report("mid_b", got.mid_b, e.mid_b);
      if (got.mid_c !== e.mid_c) report("mid_c", got.mid_c, e.mid_c);
      if (got.source_case !== e.source_case)
        report("source_case", 8'(got.source_case), 8'(e.source_case));
    endfunction

    function void report(string fld, logic [7:0] got, logic [7:0] want);
      errors++;
      if (errors < 40) $display("ERROR: %s got %0h expected %0h", fld, got, want);
    endfunction
  endclass

  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  fwmb_in_if  in_if();
  fwmb_out_if out_if();
  fwmb_cfg_if cfg_if();

  flow_warp_midframe_blend dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  always #5 clk_i = ~clk_i;

  blend_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_off = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    in_if.valid = 0; in_if.func = FUNC_LOAD0; in_if.pos_x = 0; in_if.pos_y = 0;
    in_if.chan_a = 0; in_if.chan_b = 0; in_if.chan_c = 0;
    in_if.flow_x = 0; in_if.flow_y = 0;
    out_if.ready = 0;
    cfg_if.valid = 0; cfg_if.index = CFG_WIDTH; cfg_if.data = 0;
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_if.ready <= 0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 5);
        out_if.ready <= 0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_if.ready <= 1;
      end
    end
  end

  // Check results and count quiet cycles for the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_if.valid && out_if.ready)
        sb.check_result({out_if.mid_a, out_if.mid_b, out_if.mid_c, out_if.source_case});
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one transaction, advance when accepted, then note it.
  task automatic send_item(func_e fn, int px, int py, logic [23:0] pv, int fx, int fy);
    int n;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 5);
      in_if.valid <= 0;
      repeat (n) @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.func <= fn;
    in_if.pos_x <= px[7:0];
    in_if.pos_y <= py[7:0];
    {in_if.chan_c, in_if.chan_b, in_if.chan_a} <= pv;
    in_if.flow_x <= fx[15:0];
    in_if.flow_y <= fy[15:0];
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(fn, px[7:0], py[7:0], pv, fx[15:0], fy[15:0]);
  endtask

  task automatic drain();
    in_if.valid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Offer one register write and hold valid; the caller drops it after the last one.
  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= val[8:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_WIDTH:  sb.width_cfg = val[8:0];
      CFG_HEIGHT: sb.height_cfg = val[8:0];
      CFG_MODE:   sb.fwd_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(int w, int h, int m);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_MODE, m);
    cfg_if.valid <= 0;
    @(posedge clk_i);
  endtask

  // Load every pixel of a w by h frame pair so no unwritten entry gets read.
  task automatic load_frames(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        send_item(FUNC_LOAD0, x, y, 24'($urandom), 0, 0);
        send_item(FUNC_LOAD1, x, y, 24'($urandom), 0, 0);
      end
  endtask

  // Random flow: mostly in-frame vectors, some extremes.
  function automatic int rand_flow(int lim);
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 65535)) - 32768;
      default: return int'($urandom_range(0, 2 * lim)) - lim;
    endcase
  endfunction

  task automatic random_interps(int cnt, int w, int h, int fb);
    int pick;
    for (int i = 0; i < cnt; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        send_item(FUNC_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                  24'($urandom), rand_flow(100), rand_flow(100));
      else if (pick == 1)
        // reload an in-frame pixel with new content
        send_item(func_e'($urandom_range(0, 1)), $urandom_range(0, w - 1),
                  $urandom_range(0, h - 1), 24'($urandom), 0, 0);
      else if (pick == 2)
        // position outside the frame in use: no result
        send_item(FUNC_INTERP, $urandom_range(0, 255), $urandom_range(h, 255) % 256,
                  24'($urandom), rand_flow(50), rand_flow(50));
      else
        send_item(FUNC_INTERP, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                  24'($urandom), rand_flow(w << fb), rand_flow(h << fb));
    end
  endtask

  initial begin
    @(posedge clk_i);
    @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: tiny frame, extremes of fields and flows, both modes.
    configure(2, 2, 0);
    send_item(FUNC_LOAD0, 0, 0, 24'hFFFFFF, 0, 0);
    send_item(FUNC_LOAD0, 1, 0, 24'hFFFFFF, 0, 0);
    send_item(FUNC_LOAD0, 0, 1, 24'hFFFFFF, 0, 0);
    send_item(FUNC_LOAD0, 1, 1, 24'h000000, 0, 0);
    send_item(FUNC_LOAD1, 0, 0, 24'h000000, 0, 0);
    send_item(FUNC_LOAD1, 1, 0, 24'hFF00FF, 0, 0);
    send_item(FUNC_LOAD1, 0, 1, 24'h00FF00, 0, 0);
    send_item(FUNC_LOAD1, 1, 1, 24'hFFFFFF, 0, 0);
    send_item(FUNC_INTERP, 0, 0, 0, 0, 0);
    send_item(FUNC_INTERP, 0, 0, 0, -8, -8);
    send_item(FUNC_INTERP, 0, 0, 0, 8, 8);
    send_item(FUNC_INTERP, 1, 1, 0, 7, 9);
    send_item(FUNC_INTERP, 1, 1, 0, 32767, -32768);
    send_item(FUNC_INTERP, 0, 0, 0, -32768, 32767);
    send_item(FUNC_INTERP, 255, 255, 24'hFFFFFF, 0, 0);
    send_item(FUNC_NONE, 255, 255, 24'hFFFFFF, -1, -1);
    drain();
    configure(2, 2, 1);
    send_item(FUNC_INTERP, 0, 0, 0, -1, -1);
    send_item(FUNC_INTERP, 0, 0, 0, -31, -17);
    send_item(FUNC_INTERP, 1, 0, 0, 1, 0);
    send_item(FUNC_INTERP, 1, 1, 0, 16, 16);
    drain();
    // Oversized and one-column frames.
    configure(511, 300, 0);
    send_item(FUNC_INTERP, 0, 0, 0, 0, 0);
    drain();
    configure(1, 0, 0);
    send_item(FUNC_INTERP, 0, 0, 0, 0, 0);
    drain();

    // Random phases over several frame sizes and both modes.
    configure(8, 6, 0);
    load_frames(8, 6);
    random_interps(300, 8, 6, 4);
    // Long receiver hold-off while the sender keeps offering.
    hold_off = 1;
    random_interps(100, 8, 6, 4);
    drain();
    configure(8, 6, 1);
    random_interps(300, 8, 6, 5);
    drain();
    configure(3, 16, 0);
    load_frames(3, 16);
    random_interps(250, 3, 16, 4);
    drain();
    configure(16, 3, 1);
    load_frames(16, 3);
    random_interps(200, 16, 3, 5);
    drain();
    configure(5, 5, 0);
    no_idle = 1;
    random_interps(390, 5, 5, 4);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
